FILE: src/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, widths and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int ADDR_BITS      = 24;
	localparam int OWNER_BITS     = 8;
	localparam int SZ_W           = ADDR_BITS + 1;
	localparam int CFG_LIMIT_W    = 5;
	localparam int LIVE_W         = 5;
	localparam int CFG_IDX_W      = 2;
	localparam int MAX_BLOCKS_DEF = 16;

	localparam logic [SZ_W-1:0] SPACE_CAP = {1'b1, {ADDR_BITS{1'b0}}};

	localparam logic [SZ_W-1:0]        TOTAL_MEMORY_RST  = SZ_W'(16384);
	localparam logic [SZ_W-1:0]        PROCESS_SIZE_RST  = SZ_W'(4096);
	localparam logic [CFG_LIMIT_W-1:0] PROCESS_LIMIT_RST = CFG_LIMIT_W'(4);

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_MEMORY  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_SIZE  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_LIMIT = CFG_IDX_W'(2);

	typedef enum logic [1:0] {
		OP_ADMIT   = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RELEASE = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ALU_FIT  = 2'd0,
		ALU_ADD  = 2'd1,
		ALU_REL  = 2'd2,
		ALU_FREE = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic [OWNER_BITS-1:0] owner;
		logic [SZ_W-1:0]       hi;
		logic [ADDR_BITS-1:0]  lo;
	} ent_t;

	typedef struct packed {
		alu_op_t         op;
		logic [SZ_W-1:0] a;
		logic [SZ_W-1:0] b;
		logic [SZ_W-1:0] c;
		logic [SZ_W-1:0] lim;
	} alu_in_t;

	typedef struct packed {
		logic [SZ_W-1:0] res;
		logic            fit_gap;
		logic            fit_lim;
		logic [SZ_W-1:0] free;
	} alu_out_t;

	typedef struct packed {
		logic [SZ_W-1:0]        psize;
		logic [CFG_LIMIT_W-1:0] plimit;
		logic [SZ_W-1:0]        lim;
	} cfg_view_t;

	// first member lands in the top bits, so success sits at bit 0
	typedef struct packed {
		logic [SZ_W-1:0]      free_space;
		logic [LIVE_W-1:0]    live_blocks;
		logic                 owner_present;
		logic [ADDR_BITS-1:0] start_address;
		logic                 success;
	} res_t;

	localparam int IN_TDATA_W  = ((OWNER_BITS + SZ_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = (($bits(res_t) + 7) / 8) * 8;

endpackage

FILE: src/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffba_table
	import ffba_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	localparam int IDX_W = $clog2(MAX_BLOCKS)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  ent_t             wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output ent_t             rd_data
);

	ent_t mem_q [MAX_BLOCKS];
	ent_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

FILE: src/ffba_alu.sv
// ----------------------------------------------------------------------------
// ffba_alu
// Shared adder and comparator: gap fit test, used-byte update, free space.
// ----------------------------------------------------------------------------
module ffba_alu
	import ffba_pkg::*;
(
	input  alu_in_t  req,
	output alu_out_t rsp
);

	localparam int W = SZ_W + 2;

	logic [W-1:0] p;
	logic [W-1:0] q;
	logic [W-1:0] r;
	logic [W-1:0] s;
	logic         cin;

	always_comb begin
		p   = W'(req.a);
		q   = W'(req.b);
		r   = '0;
		cin = 1'b0;
		case (req.op)
			ALU_FIT, ALU_ADD: ;
			ALU_REL: begin
				// used - hi + lo
				q   = ~W'(req.b);
				r   = W'(req.c);
				cin = 1'b1;
			end
			ALU_FREE: begin
				p   = W'(req.lim);
				q   = ~W'(req.a);
				cin = 1'b1;
			end
			default: ;
		endcase
		s = p + q + r + W'(cin);

		rsp.res     = s[SZ_W-1:0];
		rsp.fit_gap = (s <= W'(req.c));
		rsp.fit_lim = (s <= W'(req.lim));
		// clamp at zero when the space has shrunk below the used bytes
		rsp.free    = s[W-1] ? '0 : s[SZ_W-1:0];
	end

endmodule

FILE: src/ffba_seq.sv
// ----------------------------------------------------------------------------
// ffba_seq
// Request sequencer: walks the table one entry at a time through the shared
// unit, shifts entries up to insert and packs them down to release.
// ----------------------------------------------------------------------------
module ffba_seq
	import ffba_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  op_t                   in_op,
	input  logic [OWNER_BITS-1:0] in_owner,
	input  logic [SZ_W-1:0]       in_size,
	input  cfg_view_t             cfg,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_SCAN_RD = 10'b00_0000_0010,
		S_SCAN_EV = 10'b00_0000_0100,
		S_DECIDE  = 10'b00_0000_1000,
		S_MOVE_RD = 10'b00_0001_0000,
		S_MOVE_WR = 10'b00_0010_0000,
		S_INSERT  = 10'b00_0100_0000,
		S_REL_RD  = 10'b00_1000_0000,
		S_REL_EV  = 10'b01_0000_0000,
		S_DONE    = 10'b10_0000_0000
	} state_t;

	state_t                state_q;
	op_t                   op_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [SZ_W-1:0]       size_q;
	logic [CNT_W-1:0]      count_q;
	logic [SZ_W-1:0]       used_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      wr_q;
	logic [CNT_W-1:0]      pos_q;
	logic [SZ_W-1:0]       prev_q;
	logic [SZ_W-1:0]       end_q;
	logic                  found_q;
	logic                  held_q;
	logic                  ok_q;
	logic [ADDR_BITS-1:0]  where_q;
	logic                  present_q;

	logic [CNT_W-1:0] idx_inc;
	logic [CNT_W-1:0] idx_dec;
	logic [CNT_W-1:0] wr_inc;
	logic             owner_hit;
	logic             can_place;
	logic             below_plim;
	logic             place_now;

	ent_t             rd_ent;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	ent_t             wr_data;
	alu_in_t          alu_i;
	alu_out_t         alu_o;

	ffba_table #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_ent)
	);

	ffba_alu u_alu (
		.req(alu_i),
		.rsp(alu_o)
	);

	assign idx_inc    = idx_q + CNT_W'(1);
	assign idx_dec    = idx_q - CNT_W'(1);
	assign wr_inc     = wr_q + CNT_W'(1);
	assign owner_hit  = (rd_ent.owner == owner_q);
	assign below_plim = (32'(count_q) < 32'(cfg.plimit));
	assign can_place  = (size_q != '0) && (count_q < CNT_W'(MAX_BLOCKS))
		&& (found_q || alu_o.fit_lim);
	assign place_now  = can_place && ((op_q == OP_ALLOC)
		|| ((op_q == OP_ADMIT) && !held_q && below_plim));

	// table port steering
	always_comb begin
		rd_addr = idx_q[IDX_W-1:0];
		if (state_q == S_MOVE_RD) begin
			rd_addr = idx_dec[IDX_W-1:0];
		end
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_ent;
		case (state_q)
			S_MOVE_WR: wr_en = 1'b1;
			S_INSERT: begin
				wr_en         = 1'b1;
				wr_addr       = pos_q[IDX_W-1:0];
				wr_data.lo    = prev_q[ADDR_BITS-1:0];
				wr_data.hi    = end_q;
				wr_data.owner = owner_q;
			end
			S_REL_EV: begin
				// keep entries of other owners, packed down
				wr_en   = !owner_hit;
				wr_addr = wr_q[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	// shared unit operand selection
	always_comb begin
		alu_i.op  = ALU_FIT;
		alu_i.a   = prev_q;
		alu_i.b   = size_q;
		alu_i.c   = SZ_W'(rd_ent.lo);
		alu_i.lim = cfg.lim;
		case (state_q)
			S_INSERT: begin
				alu_i.op = ALU_ADD;
				alu_i.a  = used_q;
			end
			S_REL_EV: begin
				alu_i.op = ALU_REL;
				alu_i.a  = used_q;
				alu_i.b  = rd_ent.hi;
			end
			S_DONE: begin
				alu_i.op = ALU_FREE;
				alu_i.a  = used_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			used_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_op == OP_RELEASE) begin
							state_q <= (count_q == '0) ? S_DONE : S_REL_RD;
						end else begin
							state_q <= (count_q == '0) ? S_DECIDE : S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: state_q <= (idx_inc == count_q) ? S_DECIDE : S_SCAN_RD;
				S_DECIDE: begin
					if (place_now) begin
						state_q <= found_q ? S_MOVE_RD : S_INSERT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MOVE_RD: state_q <= S_MOVE_WR;
				S_MOVE_WR: state_q <= (idx_dec == pos_q) ? S_INSERT : S_MOVE_RD;
				S_INSERT: begin
					state_q <= S_DONE;
					count_q <= count_q + CNT_W'(1);
					used_q  <= alu_o.res;
				end
				S_REL_RD: state_q <= S_REL_EV;
				S_REL_EV: begin
					if (owner_hit) begin
						used_q <= alu_o.res;
					end
					if (idx_inc == count_q) begin
						state_q <= S_DONE;
						count_q <= owner_hit ? wr_q : wr_inc;
					end else begin
						state_q <= S_REL_RD;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q      <= in_op;
				owner_q   <= in_owner;
				size_q    <= (in_op == OP_ADMIT) ? cfg.psize : in_size;
				idx_q     <= '0;
				wr_q      <= '0;
				prev_q    <= '0;
				found_q   <= 1'b0;
				held_q    <= 1'b0;
				ok_q      <= 1'b0;
				where_q   <= '0;
				present_q <= 1'b0;
			end
			S_SCAN_EV: begin
				if (owner_hit) begin
					held_q <= 1'b1;
				end
				// first gap wins; later entries only feed the owner check
				if (!found_q) begin
					if (alu_o.fit_gap && alu_o.fit_lim) begin
						found_q <= 1'b1;
						pos_q   <= idx_q;
					end else begin
						prev_q <= rd_ent.hi;
					end
				end
				idx_q <= idx_inc;
			end
			S_DECIDE: begin
				end_q <= alu_o.res;
				if (place_now) begin
					ok_q      <= 1'b1;
					present_q <= 1'b1;
					where_q   <= prev_q[ADDR_BITS-1:0];
					idx_q     <= count_q;
					if (!found_q) begin
						pos_q <= count_q;
					end
				end else begin
					// an admit by an owner that already holds a block succeeds
					present_q <= held_q;
					ok_q      <= (op_q == OP_ADMIT) && held_q;
				end
			end
			S_MOVE_WR: idx_q <= idx_dec;
			S_REL_EV: begin
				if (!owner_hit) begin
					wr_q <= wr_inc;
				end
				idx_q <= idx_inc;
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.success       = ok_q;
		res.start_address = where_q;
		res.owner_present = present_q;
		res.live_blocks   = LIVE_W'(count_q);
		res.free_space    = alu_o.free;
	end

endmodule

FILE: src/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Owner-tagged address range allocator with a first-fit placement scan.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the operation (admit,
// allocate, release, query), tdata the owner id and the requested size. Each
// request gives one result beat on m_axis with success, start address, owner
// presence, live block count and free space.
// The cfg channel writes total_memory, process_size and process_limit; it is
// always ready and is meant to be used while no request is in flight.
// An admit, allocation or query scans all live blocks; one that places a block
// moves the entries above its position up one by one before it inserts. The
// table has a single read port with registered data, so every entry visited
// passes through a read state and an evaluate state; release walks them alike.
// A new request is taken in the cycle after the result has moved to the
// output register, so it overlaps a result that still waits.
// Reset empties the table at once (the live count is cleared, no sweep) and
// loads the register defaults. A stalled receiver holds the output beat and,
// once a second result is finished, holds the sequencer until it drains.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// owner_id, request_size
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// success, start_address, owner_present, live_blocks, free_space
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SZ_W-1:0]        cfg_data
);

	logic [SZ_W-1:0]        total_q;
	logic [SZ_W-1:0]        psize_q;
	logic [CFG_LIMIT_W-1:0] plimit_q;
	logic                   out_valid_q;
	res_t                   out_q;

	cfg_view_t cfg_view;
	logic      res_valid;
	logic      res_ready;
	res_t      res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= TOTAL_MEMORY_RST;
			psize_q  <= PROCESS_SIZE_RST;
			plimit_q <= PROCESS_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TOTAL_MEMORY:  total_q  <= cfg_data;
				REG_PROCESS_SIZE:  psize_q  <= cfg_data;
				REG_PROCESS_LIMIT: plimit_q <= cfg_data[CFG_LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_view.psize  = psize_q;
		cfg_view.plimit = plimit_q;
		// clamp the managed space to the address range
		cfg_view.lim    = (total_q > SPACE_CAP) ? SPACE_CAP : total_q;
	end

	ffba_seq #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (op_t'(s_axis_tuser)),
		.in_owner (s_axis_tdata[OWNER_BITS-1:0]),
		.in_size  (s_axis_tdata[OWNER_BITS +: SZ_W]),
		.cfg      (cfg_view),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_q);

endmodule

FILE: src/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffba_checker
	import ffba_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [1:0]             s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [CFG_IDX_W-1:0]   cfg_index,
	input logic [SZ_W-1:0]        cfg_data
);

	res_t beat;

	assign beat = m_axis_tdata[$bits(res_t)-1:0];

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// one request at a time: the input closes after every accepted beat
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	// a successful admit or allocate leaves the owner holding a block
	a_success_present: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !beat.success || beat.owner_present)
		else $error("success without owner present");

	// a start address is reported only for a placed block
	a_start_success: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (beat.start_address != '0) |-> beat.success)
		else $error("start address on a failed request");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
